@@ rtl/core/bmp_pkg.sv @@
// ============================================================================
// bmp_pkg: shared types and constants for the binomial mod p block
// Holds the field widths, the per-cell control bundle and the controller
// state encoding.
// ============================================================================
`default_nettype none

package bmp_pkg;

    // Field widths of the item and result channels.
    localparam int N_W   = 12;
    localparam int VAL_W = 31;

    // Control bundle broadcast from the controller to every row cell.
    typedef struct packed {
        logic clear;   // zero the entry at the start of an item
        logic update;  // apply one step of Pascal's rule
        logic shift;   // move the row one place toward the head
    } cell_ctrl_t;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLEAR  = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

endpackage : bmp_pkg

`default_nettype wire

@@ rtl/core/bmp_cell.sv @@
// ============================================================================
// bmp_cell: one entry of the Pascal row
// Holds row[j] and, on each update step, replaces it with
// (row[j] + row[j-1]) mod p using one add and one compare-subtract.
// ============================================================================
`default_nettype none

module bmp_cell (
    input  wire logic                       aclk,
    input  wire bmp_pkg::cell_ctrl_t        ctrl,
    input  wire logic [bmp_pkg::VAL_W-1:0]  modulus,
    input  wire logic [bmp_pkg::VAL_W-1:0]  left_val,
    input  wire logic [bmp_pkg::VAL_W-1:0]  right_val,
    output logic      [bmp_pkg::VAL_W-1:0]  entry_val
);
    import bmp_pkg::*;

    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W:0]   sum;
    logic [VAL_W:0]   sum_minus_p;
    logic [VAL_W-1:0] mod_sum;

    // Both operands stay below p (the head entry is 1), so the sum is below 2p
    // and one conditional subtract finishes the reduction.
    always_comb begin
        sum         = {1'b0, entry_reg} + {1'b0, left_val};
        sum_minus_p = sum - {1'b0, modulus};
        if (sum >= {1'b0, modulus}) begin
            mod_sum = sum_minus_p[VAL_W-1:0];
        end else begin
            mod_sum = sum[VAL_W-1:0];
        end
    end

    // Entry register: clear, update or take the right neighbor's value.
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            entry_reg <= '0;
        end else if (ctrl.update) begin
            entry_reg <= mod_sum;
        end else if (ctrl.shift) begin
            entry_reg <= right_val;
        end
    end

    assign entry_val = entry_reg;

endmodule : bmp_cell

`default_nettype wire

@@ rtl/core/binomial_mod_p.sv @@
// ============================================================================
// binomial_mod_p: binomial coefficient C(n,r) mod p by Pascal's rule
// A controller and a chain of row cells that build row n of Pascal's
// triangle reduced mod p, then shift the wanted entry out to the head.
// ============================================================================
// Usage:
//   The s_ channel takes one item (s_total_n, s_choose_r, s_modulus_p) when
//   s_valid and s_ready are both high; the m_ channel returns one result
//   (m_binom_value, m_error_flag) per item under m_valid/m_ready.
//   The block works on one item at a time; s_ready is high only while idle.
//   With r' = min(r, n-r), a normal item takes these steps after acceptance:
//   the row is cleared, every cell applies n steps of Pascal's rule in
//   parallel, entry r' is shifted down to the head cell, and the result is
//   presented in the output register. Items with p = 0, n > MAX_N, r > n or
//   r' > MAX_R skip the row and go straight to the result: zero, with the
//   error flag set for all but r > n.
//   The result sits in an output register; the block returns to idle and
//   accepts the next item while that result waits. A second result waits in
//   the controller until the receiver takes the first.
//   Reset (aresetn low, synchronous) empties the output register and returns
//   the controller to idle; the row holds no state between items.
// ============================================================================
`default_nettype none

module binomial_mod_p #(
    parameter int MAX_R = 1023,
    parameter int MAX_N = 4095
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [bmp_pkg::N_W-1:0]    s_total_n,
    input  wire logic [bmp_pkg::N_W-1:0]    s_choose_r,
    input  wire logic [bmp_pkg::VAL_W-1:0]  s_modulus_p,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [bmp_pkg::VAL_W-1:0]  m_binom_value,
    output logic                            m_error_flag
);
    import bmp_pkg::*;

    // Controller registers.
    state_t           state_reg,   state_next;
    logic [N_W-1:0]   n_cnt_reg,   n_cnt_next;
    logic [N_W-1:0]   r_cnt_reg,   r_cnt_next;
    logic             m_valid_reg, m_valid_next;

    // Payload registers.
    logic [VAL_W-1:0] p_reg,       p_next;
    logic [VAL_W-1:0] res_val_reg, res_val_next;
    logic             res_err_reg, res_err_next;
    logic [VAL_W-1:0] m_val_reg,   m_val_next;
    logic             m_err_reg,   m_err_next;
    logic [VAL_W-1:0] head_reg;

    // Row chain; the extra slot past the last cell feeds zeros during shifts.
    logic [VAL_W-1:0] row_val [0:MAX_R+1];
    cell_ctrl_t       ctrl;

    // Item screening.
    logic             s_fire;
    logic             zero_p;
    logic             big_n;
    logic             r_gt_n;
    logic             big_r;
    logic [N_W-1:0]   n_minus_r;
    logic [N_W-1:0]   r_red;
    logic             out_free;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Special-case checks and the reduction r' = min(r, n-r).
    always_comb begin
        zero_p    = (s_modulus_p == '0);
        big_n     = (32'(s_total_n) > 32'(MAX_N));
        r_gt_n    = (s_choose_r > s_total_n);
        n_minus_r = s_total_n - s_choose_r;
        r_red     = (s_choose_r > n_minus_r) ? n_minus_r : s_choose_r;
        big_r     = (32'(r_red) > 32'(MAX_R));
    end

    // Controller next state.
    always_comb begin
        state_next   = state_reg;
        n_cnt_next   = n_cnt_reg;
        r_cnt_next   = r_cnt_reg;
        m_valid_next = m_valid_reg;
        p_next       = p_reg;
        res_val_next = res_val_reg;
        res_err_next = res_err_reg;
        m_val_next   = m_val_reg;
        m_err_next   = m_err_reg;
        ctrl         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    n_cnt_next   = s_total_n;
                    r_cnt_next   = r_red;
                    p_next       = s_modulus_p;
                    res_val_next = '0;
                    if (zero_p || big_n) begin
                        res_err_next = 1'b1;
                        state_next   = ST_DONE;
                    end else if (r_gt_n) begin
                        res_err_next = 1'b0;
                        state_next   = ST_DONE;
                    end else if (big_r) begin
                        res_err_next = 1'b1;
                        state_next   = ST_DONE;
                    end else begin
                        res_err_next = 1'b0;
                        state_next   = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                ctrl.clear = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // One row of Pascal's triangle per cycle, n rows in all.
                if (n_cnt_reg != '0) begin
                    ctrl.update = 1'b1;
                    n_cnt_next  = n_cnt_reg - 1'b1;
                end else begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                // Walk entry r' down to the head cell.
                if (r_cnt_reg != '0) begin
                    ctrl.shift = 1'b1;
                    r_cnt_next = r_cnt_reg - 1'b1;
                end else begin
                    res_val_next = head_reg;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_err_next   = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_cnt_reg   <= '0;
            r_cnt_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_cnt_reg   <= n_cnt_next;
            r_cnt_reg   <= r_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        res_val_reg <= res_val_next;
        res_err_reg <= res_err_next;
        m_val_reg   <= m_val_next;
        m_err_reg   <= m_err_next;
    end

    // Head cell: entry 0 is 1 and is never reduced; it takes part in shifts.
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            head_reg <= VAL_W'(1);
        end else if (ctrl.shift) begin
            head_reg <= row_val[1];
        end
    end

    assign row_val[0]       = head_reg;
    assign row_val[MAX_R+1] = '0;

    // Chain of row cells, entries 1 to MAX_R.
    for (genvar j = 1; j <= MAX_R; j++) begin : g_cell
        bmp_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .modulus   (p_reg),
            .left_val  (row_val[j-1]),
            .right_val (row_val[j+1]),
            .entry_val (row_val[j])
        );
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_binom_value = m_val_reg;
    assign m_error_flag  = m_err_reg;

endmodule : binomial_mod_p

`default_nettype wire

@@ rtl/core/bmp_checker.sv @@
// ============================================================================
// bmp_checker: port-level checks for binomial_mod_p
// Watches the item and result channels and flags behavior that the block
// or its source must never show.
// ============================================================================
`default_nettype none

module bmp_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    input  wire logic                       s_ready,
    input  wire logic [bmp_pkg::N_W-1:0]    s_total_n,
    input  wire logic [bmp_pkg::N_W-1:0]    s_choose_r,
    input  wire logic [bmp_pkg::VAL_W-1:0]  s_modulus_p,
    input  wire logic                       m_valid,
    input  wire logic                       m_ready,
    input  wire logic [bmp_pkg::VAL_W-1:0]  m_binom_value,
    input  wire logic                       m_error_flag
);
    import bmp_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A waiting item holds its fields until it is taken.
    a_item_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_total_n)
            && $stable(s_choose_r) && $stable(s_modulus_p))
        else $error("waiting item changed or dropped");

    // A stalled result holds its value and flag.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_binom_value) && $stable(m_error_flag))
        else $error("stalled result changed or dropped");

    // An error result always carries a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_flag |-> m_binom_value == '0)
        else $error("error result with nonzero value");

    // The block is busy in the cycle after it takes an item.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken back to back");

endmodule : bmp_checker

bind binomial_mod_p bmp_checker u_bmp_checker (.*);

`default_nettype wire
